### design/edc_pkg.sv
// ----------------------------------------------------------------------------
// Even divisor counter package
// Shared widths and constants for the even divisor counter.
// ----------------------------------------------------------------------------
package edc_pkg;

  parameter int unsigned VALUE_BITS_DEFAULT = 31;

  // Result field
  parameter int unsigned COUNT_W = 11;
  parameter logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Odd-divisor product saturates just above the largest result
  parameter int unsigned ODD_W = 12;
  parameter logic [ODD_W-1:0] ODD_SAT = 12'd2048;

  // First odd trial candidate and its square
  parameter int unsigned FIRST_CAND = 3;
  parameter int unsigned FIRST_CAND_SQ = 9;

  // Factor for a leftover prime
  parameter int unsigned PRIME_FACTOR = 2;

endpackage

### design/even_divisor_counter_core.sv
// ----------------------------------------------------------------------------
// Even divisor counter core
// Counts the even divisors of one positive integer by trial division.
// ----------------------------------------------------------------------------
// A request runs through a sequence of states whose length depends on the
// value, with each division done by the bit-serial restoring divider. An odd
// or zero value goes straight to the final state. For an even value the block
// strips one factor of two per step until the value is odd, then for each odd
// candidate c = 3, 5, 7, ... with c*c not above the remaining value runs a
// compare, one division and an evaluation, plus one more division after each
// division that leaves no remainder, and ends with a last compare and the
// final state. Worst case at 31 bits is about 16000 candidates. The input is
// stalled while a request is in work; a finished result sits in the output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module even_divisor_counter_core #(
  parameter int unsigned VALUE_BITS = edc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [edc_pkg::COUNT_W-1:0]  even_divisor_count_o
);

  localparam int unsigned CB     = (VALUE_BITS + 1) / 2 + 1;  // candidate width
  localparam int unsigned SQ_W   = 2 * CB;
  localparam int unsigned TW     = $clog2(VALUE_BITS);
  localparam int unsigned FW     = $clog2(VALUE_BITS + 1);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned PROD_W = edc_pkg::ODD_W + FW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STRIP = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [VALUE_BITS-1:0]       v_q, v_d;
  logic [TW-1:0]               twos_q, twos_d;
  logic [FW-1:0]               k_q, k_d;
  logic [edc_pkg::ODD_W-1:0]   odd_q, odd_d;
  logic [CB-1:0]               cand_q, cand_d;
  logic [SQ_W-1:0]             sq_q, sq_d;
  logic [VALUE_BITS-1:0]       dq_q, dq_d;
  logic [CB-1:0]               rem_q, rem_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [edc_pkg::COUNT_W-1:0] out_q, out_d;

  // Divider step
  logic [CB:0]                 shifted;
  logic [CB+1:0]               diff;
  logic                        fits;

  // Shared multiplier
  logic [FW-1:0]               factor;
  logic [PROD_W-1:0]           prod;
  logic [edc_pkg::ODD_W-1:0]   odd_sat;
  logic [edc_pkg::COUNT_W-1:0] cnt_sat;

  logic                        out_free;

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign even_divisor_count_o = out_q;
  assign out_free             = !out_valid_q || !out_stall_i;

  assign shifted = {rem_q, dq_q[VALUE_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, cand_q};
  assign fits    = !diff[CB+1];

  always_comb begin
    unique case (state_q)
      ST_CHECK: factor = FW'(edc_pkg::PRIME_FACTOR);
      ST_FIN:   factor = FW'(twos_q);
      default:  factor = FW'(k_q + 1'b1);
    endcase
  end

  assign prod    = PROD_W'(odd_q) * PROD_W'(factor);
  assign odd_sat = (prod > PROD_W'(edc_pkg::ODD_SAT)) ? edc_pkg::ODD_SAT
                                                       : prod[edc_pkg::ODD_W-1:0];
  assign cnt_sat = (prod > PROD_W'(edc_pkg::COUNT_MAX)) ? edc_pkg::COUNT_MAX
                                                         : prod[edc_pkg::COUNT_W-1:0];

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    twos_d      = twos_q;
    k_d         = k_q;
    odd_d       = odd_q;
    cand_d      = cand_q;
    sq_d        = sq_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          v_d    = value_i;
          twos_d = '0;
          k_d    = '0;
          odd_d  = edc_pkg::ODD_W'(1);
          cand_d = CB'(edc_pkg::FIRST_CAND);
          sq_d   = SQ_W'(edc_pkg::FIRST_CAND_SQ);
          // Odd or zero: no twos, so the final product is zero
          if (value_i == '0 || value_i[0]) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!v_q[0]) begin
          v_d    = v_q >> 1;
          twos_d = TW'(twos_q + 1'b1);
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_q <= SQ_W'(v_q)) begin
          dq_d    = v_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          // Leftover above one is a prime
          if (v_q > VALUE_BITS'(1)) begin
            odd_d = odd_sat;
          end
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        dq_d  = {dq_q[VALUE_BITS-2:0], fits};
        rem_d = fits ? diff[CB-1:0] : shifted[CB-1:0];
        cnt_d = CNT_W'(cnt_q + 1'b1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (rem_q == '0) begin
          // Divides: keep the quotient and try the same candidate again
          v_d     = dq_q;
          k_d     = FW'(k_q + 1'b1);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          if (k_q != '0) begin
            odd_d = odd_sat;
          end
          k_d     = '0;
          cand_d  = CB'(cand_q + CB'(2));
          sq_d    = SQ_W'(sq_q + {cand_q, 2'b00} + SQ_W'(4));
          state_d = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d       = cnt_sat;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    twos_q <= twos_d;
    k_q    <= k_d;
    odd_q  <= odd_d;
    cand_q <= cand_d;
    sq_q   <= sq_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  // Assertions
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the final state");

  a_cand_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_DIV || state_q == ST_EVAL) |-> cand_q[0])
    else $error("trial candidate is even");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cand_q))
    else $error("partial remainder not below divisor");

  a_sq_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (sq_q == SQ_W'(SQ_W'(cand_q) * SQ_W'(cand_q))))
    else $error("candidate square out of step");

  a_odd_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (odd_q <= edc_pkg::ODD_SAT))
    else $error("odd divisor count above saturation");

endmodule

### tb/even_divisor_counter_core_tb.sv
// ----------------------------------------------------------------------------
// Even divisor counter testbench
// Sends directed and random values through the core under varying sender
// idling and receiver stalls, and checks each count against a trial-division
// predictor kept in the testbench.
// ----------------------------------------------------------------------------
module even_divisor_counter_core_tb;

  localparam int unsigned VALUE_BITS   = edc_pkg::VALUE_BITS_DEFAULT;
  localparam int unsigned IDLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [VALUE_BITS-1:0]       value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [edc_pkg::COUNT_W-1:0] even_divisor_count_o;

  logic [edc_pkg::COUNT_W-1:0] expected_counts [$];
  int unsigned                 mismatch_count;
  int unsigned                 quiet_cycles;
  int unsigned                 send_idle_pct;
  int unsigned                 recv_stall_pct;

  even_divisor_counter_core #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .value_i             (value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .even_divisor_count_o(even_divisor_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Number of even divisors: strip twos, factor the odd part by odd trials
  function automatic logic [edc_pkg::COUNT_W-1:0] count_even_divisors(
    logic [VALUE_BITS-1:0] value);
    longint unsigned rest;
    longint unsigned twos;
    longint unsigned odd_divs;
    longint unsigned cand;
    longint unsigned power;
    longint unsigned total;
    rest = value;
    if (rest == 0 || (rest & 1) != 0) return '0;
    twos = 0;
    while ((rest & 1) == 0) begin
      rest = rest >> 1;
      twos++;
    end
    odd_divs = 1;
    for (cand = edc_pkg::FIRST_CAND; cand * cand <= rest; cand += 2) begin
      if (rest % cand == 0) begin
        power = 0;
        while (rest % cand == 0) begin
          rest = rest / cand;
          power++;
        end
        odd_divs = odd_divs * (power + 1);
      end
    end
    if (rest > 1) odd_divs = odd_divs * edc_pkg::PRIME_FACTOR;
    total = twos * odd_divs;
    if (total > edc_pkg::COUNT_MAX) total = edc_pkg::COUNT_MAX;
    return total[edc_pkg::COUNT_W-1:0];
  endfunction

  // Mostly even values built from small primes and a short odd cofactor, so
  // that trial division stays brief; the rest is odd noise and powers of two.
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned     small_primes [8] = '{3, 5, 7, 11, 13, 17, 19, 23};
    int unsigned     kind;
    int unsigned     max_shift;
    longint unsigned odd_part;
    longint unsigned prime;
    longint unsigned cofactor;
    kind = $urandom_range(0, 99);
    if (kind < 20) return VALUE_BITS'($urandom() | 1);
    if (kind < 28) return VALUE_BITS'(64'd1 << $urandom_range(0, VALUE_BITS - 1));
    odd_part = 1;
    repeat ($urandom_range(0, 6)) begin
      prime = small_primes[$urandom_range(0, 7)];
      if (odd_part * prime < (64'd1 << (VALUE_BITS - 1))) odd_part = odd_part * prime;
    end
    cofactor = 2 * $urandom_range(0, 1023) + 1;
    if (odd_part * cofactor < (64'd1 << (VALUE_BITS - 1))) odd_part = odd_part * cofactor;
    max_shift = 1;
    while ((odd_part << (max_shift + 1)) < (64'd1 << VALUE_BITS)) max_shift++;
    return VALUE_BITS'(odd_part << $urandom_range(1, max_shift));
  endfunction

  // Offer one request and hold it until taken
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= VALUE_BITS'($urandom());
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_counts.push_back(count_even_divisors(value));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic test_odd_and_zero();
    send_value(VALUE_BITS'(1));
    send_value(VALUE_BITS'(3));
    send_value(VALUE_BITS'(0));
    send_value({VALUE_BITS{1'b1}});
    send_value(VALUE_BITS'({(VALUE_BITS + 1) / 2{2'b01}}));
  endtask

  task automatic test_powers_of_two();
    send_value(VALUE_BITS'(2));
    send_value(VALUE_BITS'(4));
    send_value(VALUE_BITS'(64'd1 << 15));
    send_value(VALUE_BITS'(64'd1 << (VALUE_BITS - 1)));
  endtask

  task automatic test_odd_factors();
    send_value(VALUE_BITS'(6));
    send_value(VALUE_BITS'(12));
    send_value(VALUE_BITS'(2 * 1000003));      // leftover prime after trials
    send_value(VALUE_BITS'(2 * 1009 * 1009));  // square of a prime: candidate squared equals rest
    send_value(VALUE_BITS'(2 * 387420489));    // high power of three
    send_value(VALUE_BITS'(223092870));        // first nine primes
    send_value(VALUE_BITS'(2095133040));       // many divisors
    send_value(VALUE_BITS'(1396755360));
    send_value(VALUE_BITS'(735134400));
    send_value({{(VALUE_BITS - 2){1'b1}}, 2'b10});
  endtask

  task automatic test_random_traffic(input int unsigned items);
    repeat (items) send_value(random_value());
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: count %0d", even_divisor_count_o);
      end else begin
        if (even_divisor_count_o !== expected_counts[0]) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("count mismatch: expected %0d actual %0d",
                     expected_counts[0], even_divisor_count_o);
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  // Drop the run when neither side moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    value_i        = '0;
    out_stall_i    = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    set_idling(0, 0);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_odd_and_zero();
    test_powers_of_two();
    test_odd_factors();

    set_idling(0, 0);
    test_random_traffic(20);
    set_idling(56, 0);
    test_random_traffic(20);
    set_idling(0, 56);
    test_random_traffic(20);
    set_idling(31, 31);
    test_random_traffic(20);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
